// ===== rtl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants of the profile replay sequencer: operation
// codes, configuration register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package prs_pkg;

  // default profile depth in entries
  localparam int unsigned PROFILE_DEPTH = 1024;

  // field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned VAL_W   = 8;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned WORD_W  = 2 * VAL_W;
  localparam int unsigned CIDX_W  = 8;

  // configuration reset values
  localparam logic [VAL_W-1:0] PAUSE_TICKS_RST    = 8'd50;
  localparam logic [VAL_W-1:0] END_VOLT_FLOOR_RST = 8'd100;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_PAUSE_TICKS    = 8'd0;
  localparam logic [CIDX_W-1:0] REG_END_VOLT_FLOOR = 8'd1;

  // operation codes carried in the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 3'd0,
    OP_TICK     = 3'd1,
    OP_SYNC     = 3'd2,
    OP_BUF_FULL = 3'd3,
    OP_CLEAR    = 3'd4
  } prs_op_e;

  // description of a pending result, travels with the memory read
  typedef struct packed {
    logic             final_entry;
    logic [IDX_W-1:0] entry_index;
  } prs_tag_t;

endpackage

// ===== rtl/prs_profile_mem.sv =====
// ----------------------------------------------------------------------------
// prs_profile_mem
// Profile storage: one write port and one read port with registered read
// data. Volt is held in the high byte of a word, ampere in the low byte.
// ----------------------------------------------------------------------------
module prs_profile_mem #(
  parameter int unsigned DEPTH = prs_pkg::PROFILE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [prs_pkg::WORD_W-1:0]  wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [prs_pkg::WORD_W-1:0]  rd_data_o
);

  logic [prs_pkg::WORD_W-1:0] mem [DEPTH];
  logic [prs_pkg::WORD_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/prs_play_ctrl.sv =====
// ----------------------------------------------------------------------------
// prs_play_ctrl
// Playback control: decodes each input transaction, updates entry count,
// play position, finished flag and pause counter, drives the profile memory
// ports and hands a result tag to the output stage. Holds the configuration
// registers.
// ----------------------------------------------------------------------------
module prs_play_ctrl #(
  parameter int unsigned DEPTH = prs_pkg::PROFILE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transaction
  input  logic                        in_fire_i,
  input  logic [prs_pkg::OP_W-1:0]    op_i,
  input  logic [prs_pkg::VAL_W-1:0]   volt_i,
  input  logic [prs_pkg::VAL_W-1:0]   ampere_i,
  // configuration write
  input  logic                        cfg_fire_i,
  input  logic [prs_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [prs_pkg::VAL_W-1:0]   cfg_data_i,
  output logic [prs_pkg::VAL_W-1:0]   end_volt_floor_o,
  // profile memory
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [prs_pkg::WORD_W-1:0]  wr_data_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  // result request
  output logic                        emit_o,
  output prs_pkg::prs_tag_t           tag_o
);

  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               pos_q, pos_d;
  logic                        fin_q, fin_d;
  logic [prs_pkg::VAL_W-1:0]   pause_q, pause_d;
  logic [prs_pkg::VAL_W-1:0]   pause_ticks_q;
  logic [prs_pkg::VAL_W-1:0]   floor_q;

  logic [AW-1:0]               count_m1;
  logic [AW-1:0]               pos_eff;
  logic                        is_last;
  logic                        is_empty;
  logic                        is_full;
  logic [prs_pkg::IDX_W-1:0]   pos_idx;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_ticks_q <= prs_pkg::PAUSE_TICKS_RST;
      floor_q       <= prs_pkg::END_VOLT_FLOOR_RST;
    end else if (cfg_fire_i) begin
      if (cfg_index_i == prs_pkg::REG_PAUSE_TICKS) begin
        pause_ticks_q <= cfg_data_i;
      end else if (cfg_index_i == prs_pkg::REG_END_VOLT_FLOOR) begin
        floor_q <= cfg_data_i;
      end
    end
  end

  assign end_volt_floor_o = floor_q;

  // position helpers
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(DEPTH));
  assign count_m1 = AW'(count_q - CW'(1));
  assign pos_eff  = (CW'(pos_q) >= count_q) ? count_m1 : pos_q;
  assign is_last  = (pos_eff == count_m1);

  // reported index is the low bits of the position
  if (AW >= prs_pkg::IDX_W) begin : g_idx_trunc
    assign pos_idx = pos_eff[prs_pkg::IDX_W-1:0];
  end else begin : g_idx_ext
    assign pos_idx = {{(prs_pkg::IDX_W - AW){1'b0}}, pos_eff};
  end

  // decode and next state
  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    fin_d     = fin_q;
    pause_d   = pause_q;
    wr_en_o   = 1'b0;
    wr_addr_o = AW'(count_q);
    wr_data_o = {volt_i, ampere_i};
    rd_en_o   = 1'b0;
    rd_addr_o = pos_eff;
    emit_o    = 1'b0;
    tag_o     = '0;
    if (in_fire_i) begin
      case (op_i)
        prs_pkg::OP_LOAD: begin
          if (!is_full) begin
            wr_en_o = 1'b1;
            count_d = count_q + CW'(1);
          end
          pos_d   = '0;
          fin_d   = 1'b0;
          pause_d = '0;
        end
        prs_pkg::OP_TICK: begin
          if (!is_empty && !fin_q) begin
            if (pause_q != '0) begin
              pause_d = pause_q - prs_pkg::VAL_W'(1);
            end else begin
              rd_en_o           = 1'b1;
              emit_o            = 1'b1;
              tag_o.entry_index = pos_idx;
              if (is_last) begin
                tag_o.final_entry = 1'b1;
                pos_d             = pos_eff;
                fin_d             = 1'b1;
              end else begin
                pos_d = pos_eff + AW'(1);
              end
            end
          end
        end
        prs_pkg::OP_SYNC: begin
          pause_d = '0;
          if (is_empty) begin
            pos_d = '0;
            fin_d = 1'b0;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            emit_o    = 1'b1;
            if (count_q == CW'(1)) begin
              pos_d = '0;
              fin_d = 1'b1;
            end else begin
              pos_d = AW'(1);
              fin_d = 1'b0;
            end
          end
        end
        prs_pkg::OP_BUF_FULL: begin
          pause_d = pause_ticks_q;
          if (!is_empty) begin
            if (fin_q) begin
              fin_d = 1'b0;
              pos_d = count_m1;
            end else if (pos_q != '0) begin
              pos_d = pos_q - AW'(1);
            end
          end
        end
        prs_pkg::OP_CLEAR: begin
          count_d = '0;
          pos_d   = '0;
          fin_d   = 1'b0;
          pause_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
      fin_q   <= 1'b0;
      pause_q <= '0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
      fin_q   <= fin_d;
      pause_q <= pause_d;
    end
  end

`ifndef SYNTHESIS
  // play position stays inside the loaded profile
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CW'(pos_q) < count_q))
    else $error("play position beyond loaded profile");

  // finished playback needs a loaded profile
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (count_q != '0))
    else $error("finished set on an empty profile");

  // entry count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count overflow");

  // a final result always leaves playback finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && tag_o.final_entry) |=> fin_q)
    else $error("final entry emitted without finishing");
`endif

endmodule

// ===== rtl/prs_out_stage.sv =====
// ----------------------------------------------------------------------------
// prs_out_stage
// Result path: holds the tag of the read in flight, shapes the read word
// (halving and volt floor on the final entry) and keeps the result register
// that drives the output stream.
// ----------------------------------------------------------------------------
module prs_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request from control, taken when ready_o is high
  input  logic                        emit_i,
  input  prs_pkg::prs_tag_t           tag_i,
  output logic                        ready_o,
  input  logic [prs_pkg::WORD_W-1:0]  rd_data_i,
  input  logic [prs_pkg::VAL_W-1:0]   end_volt_floor_i,
  // result stream
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [prs_pkg::VAL_W-1:0]   volt_o,
  output logic [prs_pkg::VAL_W-1:0]   ampere_o,
  output prs_pkg::prs_tag_t           tag_o
);

  logic                       rd_valid_q;
  prs_pkg::prs_tag_t          rd_tag_q;
  logic                       m_valid_q;
  logic [prs_pkg::VAL_W-1:0]  volt_q, volt_d;
  logic [prs_pkg::VAL_W-1:0]  amp_q, amp_d;
  prs_pkg::prs_tag_t          tag_q;
  logic                       out_free;
  logic [prs_pkg::VAL_W-1:0]  raw_volt;
  logic [prs_pkg::VAL_W-1:0]  raw_amp;
  logic [prs_pkg::VAL_W-1:0]  half_volt;

  assign out_free = !m_valid_q || m_ready_i;
  assign ready_o  = !rd_valid_q || out_free;

  // shape the read word
  assign raw_volt  = rd_data_i[prs_pkg::WORD_W-1:prs_pkg::VAL_W];
  assign raw_amp   = rd_data_i[prs_pkg::VAL_W-1:0];
  assign half_volt = raw_volt >> 1;

  always_comb begin
    volt_d = raw_volt;
    amp_d  = raw_amp;
    if (rd_tag_q.final_entry) begin
      volt_d = (half_volt < end_volt_floor_i) ? end_volt_floor_i : half_volt;
      amp_d  = raw_amp >> 1;
    end
  end

  // read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (ready_o) begin
      rd_valid_q <= emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && emit_i) begin
      rd_tag_q <= tag_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && rd_valid_q) begin
      volt_q <= volt_d;
      amp_q  <= amp_d;
      tag_q  <= rd_tag_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign volt_o    = volt_q;
  assign ampere_o  = amp_q;
  assign tag_o     = tag_q;

`ifndef SYNTHESIS
  // a read in flight is kept while the result register is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && m_valid_q && !m_ready_i) |=> (rd_valid_q && $stable(rd_tag_q)))
    else $error("pending read lost under back-pressure");
`endif

endmodule

// ===== rtl/profile_replay_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// profile_replay_sequencer_unit
// Replays a stored profile of volt/ampere pairs, one pair per tick outside a pause.
// ----------------------------------------------------------------------------
// One input transaction is taken per clock while the output keeps moving; a
// tick or sync result passes through the single read port of the profile
// memory (address issued at accept, data registered), then the result
// register. Load appends a pair and rewinds, clear empties the profile, tick
// counts down a pause or plays the next pair, sync plays the first pair and
// restarts at the second (finishes on a one-pair profile), and buffer full
// sets a pause and steps back one entry. A tick plays the last pair with both
// values halved and volt held at or above end_volt_floor. No clearing pass
// is needed after reset. Configuration: index 0 pause_ticks, index 1
// end_volt_floor: the user writes them while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module profile_replay_sequencer_unit #(
  parameter int unsigned PROFILE_DEPTH = prs_pkg::PROFILE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // volt_in[7:0], ampere_in[15:8]
  input  logic [2:0]                  s_axis_tuser,   // op[2:0]
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // volt_out[7:0], ampere_out[15:8],
                                                      // entry_index[25:16], zero[31:26]
  output logic                        m_axis_tlast,   // final_entry
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [prs_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [prs_pkg::VAL_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(PROFILE_DEPTH);
  localparam int unsigned CW = $clog2(PROFILE_DEPTH + 1);

  logic                        in_fire;
  logic                        cfg_fire;
  logic                        stage_ready;
  logic [prs_pkg::VAL_W-1:0]   floor_val;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [prs_pkg::WORD_W-1:0]  wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [prs_pkg::WORD_W-1:0]  rd_data;
  logic                        emit;
  prs_pkg::prs_tag_t           req_tag;
  prs_pkg::prs_tag_t           out_tag;
  logic [prs_pkg::VAL_W-1:0]   volt_out;
  logic [prs_pkg::VAL_W-1:0]   amp_out;

  // handshakes
  assign s_axis_tready = stage_ready;
  assign in_fire       = s_axis_tvalid && stage_ready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i;

  prs_play_ctrl #(
    .DEPTH (PROFILE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_fire_i        (in_fire),
    .op_i             (s_axis_tuser),
    .volt_i           (s_axis_tdata[7:0]),
    .ampere_i         (s_axis_tdata[15:8]),
    .cfg_fire_i       (cfg_fire),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .end_volt_floor_o (floor_val),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .emit_o           (emit),
    .tag_o            (req_tag)
  );

  prs_profile_mem #(
    .DEPTH (PROFILE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  prs_out_stage u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .emit_i           (emit),
    .tag_i            (req_tag),
    .ready_o          (stage_ready),
    .rd_data_i        (rd_data),
    .end_volt_floor_i (floor_val),
    .m_valid_o        (m_axis_tvalid),
    .m_ready_i        (m_axis_tready),
    .volt_o           (volt_out),
    .ampere_o         (amp_out),
    .tag_o            (out_tag)
  );

  // result packing
  assign m_axis_tdata = {6'd0, out_tag.entry_index, amp_out, volt_out};
  assign m_axis_tlast = out_tag.final_entry;

endmodule

// ===== tb/tb_profile_replay_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_profile_replay_sequencer_unit
// Self-checking bench for the profile replay sequencer. A directed table
// covers the empty, single-pair, finished, paused and stepped-back cases.
// Random phases under several register settings follow, along with one
// pass that fills the whole profile past its end. Every accepted input
// transaction runs through a local replay predictor, and results are
// compared field by field, in order, with its forecast or a typed row's result.
// ----------------------------------------------------------------------------
module tb_profile_replay_sequencer_unit;

  // spare op codes, ignored by the block
  localparam logic [prs_pkg::OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [prs_pkg::OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [prs_pkg::OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  localparam int          SETTLE_CYCLES = 8;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 65;
  localparam int          DIRECTED_ROWS = 25;
  localparam int unsigned MEM_AW        = $clog2(prs_pkg::PROFILE_DEPTH);

  typedef struct packed {
    logic [prs_pkg::VAL_W-1:0] volt;
    logic [prs_pkg::VAL_W-1:0] amp;
    logic [prs_pkg::IDX_W-1:0] idx;
    logic                      fin;
  } drive_t;

  typedef struct packed {
    logic [prs_pkg::OP_W-1:0]  op;
    logic [prs_pkg::VAL_W-1:0] volt;
    logic [prs_pkg::VAL_W-1:0] amp;
    logic                      typed;
    logic                      has_res;
    drive_t                    res;
  } row_t;

  localparam drive_t NO_DRIVE = '0;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [15:0]                 s_axis_tdata = '0;
  logic [2:0]                  s_axis_tuser = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [31:0]                 m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [prs_pkg::CIDX_W-1:0]  cfg_index_i = '0;
  logic [prs_pkg::VAL_W-1:0]   cfg_data_i = '0;

  // predictor state
  logic [prs_pkg::WORD_W-1:0]  profile_mem [prs_pkg::PROFILE_DEPTH];
  int unsigned                 prof_count = 0;
  int unsigned                 play_pos = 0;
  bit                          play_done = 1'b0;
  int unsigned                 pause_left = 0;
  logic [prs_pkg::VAL_W-1:0]   cfg_pause = prs_pkg::PAUSE_TICKS_RST;
  logic [prs_pkg::VAL_W-1:0]   cfg_floor = prs_pkg::END_VOLT_FLOOR_RST;

  drive_t                      expected_drives [$];
  int                          fail_count = 0;
  bit                          calm = 1'b0;
  int                          stall_left = 0;

  profile_replay_sequencer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // replay predictor: one input item in, zero or one drive pair out
  function automatic bit replay_step(input logic [prs_pkg::OP_W-1:0] op,
                                     input logic [prs_pkg::VAL_W-1:0] volt,
                                     input logic [prs_pkg::VAL_W-1:0] amp,
                                     output drive_t res);
    logic [prs_pkg::WORD_W-1:0] word;
    logic [prs_pkg::VAL_W-1:0]  v;
    logic [prs_pkg::VAL_W-1:0]  a;
    res = NO_DRIVE;
    case (op)
      prs_pkg::OP_LOAD: begin
        if (prof_count < prs_pkg::PROFILE_DEPTH) begin
          profile_mem[MEM_AW'(prof_count)] = {volt, amp};
          prof_count++;
        end
        play_pos = 0;
        play_done = 1'b0;
        pause_left = 0;
        return 1'b0;
      end
      prs_pkg::OP_TICK: begin
        if (prof_count == 0 || play_done) return 1'b0;
        if (pause_left > 0) begin
          pause_left--;
          return 1'b0;
        end
        word = profile_mem[MEM_AW'(play_pos)];
        if (play_pos == prof_count - 1) begin
          // last pair: halve both, hold volt at the floor
          v = word[15:8] >> 1;
          a = word[7:0] >> 1;
          if (v < cfg_floor) v = cfg_floor;
          play_done = 1'b1;
          res = '{volt: v, amp: a, idx: play_pos[prs_pkg::IDX_W-1:0], fin: 1'b1};
        end else begin
          res = '{volt: word[15:8], amp: word[7:0], idx: play_pos[prs_pkg::IDX_W-1:0],
                  fin: 1'b0};
          play_pos++;
        end
        return 1'b1;
      end
      prs_pkg::OP_SYNC: begin
        pause_left = 0;
        if (prof_count == 0) begin
          play_pos = 0;
          play_done = 1'b0;
          return 1'b0;
        end
        word = profile_mem[0];
        play_pos = (prof_count == 1) ? 0 : 1;
        play_done = (prof_count == 1);
        res = '{volt: word[15:8], amp: word[7:0], idx: '0, fin: 1'b0};
        return 1'b1;
      end
      prs_pkg::OP_BUF_FULL: begin
        pause_left = 32'(cfg_pause);
        if (prof_count == 0) return 1'b0;
        if (play_done) begin
          play_done = 1'b0;
          play_pos = prof_count - 1;
        end else if (play_pos > 0) begin
          play_pos--;
        end
        return 1'b0;
      end
      prs_pkg::OP_CLEAR: begin
        prof_count = 0;
        play_pos = 0;
        play_done = 1'b0;
        pause_left = 0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // optional random gap on the input side
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // one input transaction, predicted once accepted
  task automatic send_item(input logic [prs_pkg::OP_W-1:0] op,
                           input logic [prs_pkg::VAL_W-1:0] volt,
                           input logic [prs_pkg::VAL_W-1:0] amp, input bit typed = 1'b0,
                           input bit has_res = 1'b0, input drive_t res = NO_DRIVE);
    drive_t pred;
    bit     got;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {amp, volt};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    got = replay_step(op, volt, amp, pred);
    if (typed) begin
      got = has_res;
      pred = res;
    end
    if (got) expected_drives.push_back(pred);
    sender_gap();
  endtask

  // hold the input until every forecast result has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers, written while the block is idle
  task automatic write_settings(input logic [prs_pkg::VAL_W-1:0] pause,
                                input logic [prs_pkg::VAL_W-1:0] floor);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= prs_pkg::REG_PAUSE_TICKS;
    cfg_data_i  <= pause;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_pause = pause;
    cfg_index_i <= prs_pkg::REG_END_VOLT_FLOOR;
    cfg_data_i  <= floor;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_floor = floor;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [prs_pkg::VAL_W-1:0] rand_val();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return prs_pkg::VAL_W'($urandom_range(0, 255));
  endfunction

  // op mix for playback once a profile is loaded
  function automatic logic [prs_pkg::OP_W-1:0] play_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return prs_pkg::OP_TICK;
    if (r < 88) return prs_pkg::OP_SYNC;
    if (r < 96) return prs_pkg::OP_BUF_FULL;
    return prs_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // one random phase: mostly load-then-play runs, some noise
  task automatic random_phase(input int quota);
    int                        done_items;
    int                        kind;
    int                        n;
    logic [prs_pkg::OP_W-1:0]  op;
    done_items = 0;
    while (done_items < quota) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(prs_pkg::OP_CLEAR, rand_val(), rand_val());
          done_items++;
        end
        n = $urandom_range(1, 12);
        repeat (n) begin
          if (done_items < quota) begin
            send_item(prs_pkg::OP_LOAD, rand_val(), rand_val());
            done_items++;
          end
        end
        repeat (n + $urandom_range(0, 6)) begin
          if (done_items < quota) begin
            op = play_op();
            send_item(op, rand_val(), rand_val());
            done_items++;
          end
        end
      end else if (kind <= 8) begin
        repeat ($urandom_range(1, 8)) begin
          if (done_items < quota) begin
            op = prs_pkg::OP_W'($urandom_range(prs_pkg::OP_LOAD, OP_UNUSED_HI));
            send_item(op, rand_val(), rand_val());
            done_items++;
          end
        end
      end else begin
        settle();
      end
    end
  endtask

  // full profile: overfill by one, then play the first pairs and step back
  task automatic fill_and_play();
    send_item(prs_pkg::OP_CLEAR, '0, '0);
    repeat (prs_pkg::PROFILE_DEPTH + 1) send_item(prs_pkg::OP_LOAD, rand_val(), rand_val());
    send_item(prs_pkg::OP_SYNC, '0, '0);
    send_item(prs_pkg::OP_TICK, '0, '0);
    send_item(prs_pkg::OP_TICK, '0, '0);
    send_item(prs_pkg::OP_BUF_FULL, '0, '0);
    send_item(prs_pkg::OP_TICK, '0, '0);
    send_item(prs_pkg::OP_CLEAR, '0, '0);
  endtask

  // result side: random stalls and in-order comparison
  always @(posedge clk_i) begin : result_check
    drive_t got;
    drive_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{volt: m_axis_tdata[7:0], amp: m_axis_tdata[15:8],
              idx: m_axis_tdata[25:16], fin: m_axis_tlast};
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = expected_drives.pop_front();
        if (got.volt != want.volt) begin
          $display("%0t: volt_out expected %0d actual %0d", $time, want.volt, got.volt);
          fail_count++;
        end
        if (got.amp != want.amp) begin
          $display("%0t: ampere_out expected %0d actual %0d", $time, want.amp, got.amp);
          fail_count++;
        end
        if (got.idx != want.idx) begin
          $display("%0t: entry_index expected %0d actual %0d", $time, want.idx, got.idx);
          fail_count++;
        end
        if (got.fin != want.fin) begin
          $display("%0t: final_entry expected %0d actual %0d", $time, want.fin, got.fin);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // stimulus
  initial begin : stimulus
    row_t                      directed [DIRECTED_ROWS];
    logic [prs_pkg::VAL_W-1:0] phase_pause [PHASES];
    logic [prs_pkg::VAL_W-1:0] phase_floor [PHASES];
    directed = '{
      '{prs_pkg::OP_TICK,     8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_SYNC,     8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_BUF_FULL, 8'hFF, 8'hFF, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_CLEAR,    8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_LOAD,     8'hFF, 8'hFF, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_TICK,     8'h00, 8'h00, 1'b1, 1'b1, drive_t'{8'h7F, 8'h7F, 10'd0, 1'b1}},
      '{prs_pkg::OP_TICK,     8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_SYNC,     8'h00, 8'h00, 1'b1, 1'b1, drive_t'{8'hFF, 8'hFF, 10'd0, 1'b0}},
      '{prs_pkg::OP_TICK,     8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_BUF_FULL, 8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{OP_UNUSED_LO,         8'h55, 8'hAA, 1'b1, 1'b0, NO_DRIVE},
      '{OP_UNUSED_HI,         8'hFF, 8'hFF, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_LOAD,     8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_LOAD,     8'h55, 8'hAA, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_TICK,     8'h00, 8'h00, 1'b1, 1'b1, drive_t'{8'hFF, 8'hFF, 10'd0, 1'b0}},
      '{prs_pkg::OP_BUF_FULL, 8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_SYNC,     8'h00, 8'h00, 1'b1, 1'b1, drive_t'{8'hFF, 8'hFF, 10'd0, 1'b0}},
      '{prs_pkg::OP_TICK,     8'h00, 8'h00, 1'b1, 1'b1, drive_t'{8'h00, 8'h00, 10'd1, 1'b0}},
      '{prs_pkg::OP_TICK,     8'h00, 8'h00, 1'b1, 1'b1, drive_t'{8'h64, 8'h55, 10'd2, 1'b1}},
      '{prs_pkg::OP_BUF_FULL, 8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_TICK,     8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_LOAD,     8'hAA, 8'h55, 1'b1, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_BUF_FULL, 8'h00, 8'h00, 1'b1, 1'b0, NO_DRIVE},
      '{OP_UNUSED_MID,        8'h00, 8'h00, 1'b0, 1'b0, NO_DRIVE},
      '{prs_pkg::OP_CLEAR,    8'h00, 8'h00, 1'b0, 1'b0, NO_DRIVE}
    };
    phase_pause = '{8'd3, 8'd0,   8'd255, 8'd1,   8'd7,  8'd2};
    phase_floor = '{8'd100, 8'd0, 8'd255, 8'd200, 8'd37, 8'd128};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed[i].op, directed[i].volt, directed[i].amp,
                directed[i].typed, directed[i].has_res, directed[i].res);
    end
    settle();

    // random phases, with the full-profile pass after the second
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) calm = 1'b1;
      write_settings(phase_pause[p], phase_floor[p]);
      random_phase(PHASE_ITEMS);
      settle();
      if (p == 1) begin
        write_settings(8'd0, 8'd255);
        fill_and_play();
        settle();
      end
    end

    if (fail_count == 0) begin
      $display("profile_replay_sequencer_unit verification clean");
    end else begin
      $display("profile_replay_sequencer_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("profile_replay_sequencer_unit verification failed");
    $finish;
  end

endmodule
